// ===== sv/mtk_pkg.sv =====
// Shared types, constants and the key character ROM for the multi-tap key input block.
package mtk_pkg;

  localparam logic [5:0] HYBRID_KEYS   = 6'd21;
  localparam logic [6:0] TABLE_KEYS    = 7'd46;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  // character RAM: 4 rows x 64 keys, address = {row, key}
  localparam int unsigned RAM_DEPTH = 256;
  localparam int unsigned RAM_AW    = 8;
  localparam int unsigned CHAR_W    = 8;

  // request queue between the control logic and the RAM read port
  localparam int unsigned REQ_DEPTH = 4;
  localparam int unsigned REQ_AW    = 2;
  localparam int unsigned REQ_CW    = 3;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_TICK  = 2'd1,
    OP_SHIFT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_PENDING    = 2'd0,
    KIND_SWITCH     = 2'd1,
    KIND_DETERMINED = 2'd2,
    KIND_NONHYBRID  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] key;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] character;
    logic       last;
  } out_t;

  typedef struct packed {
    kind_e             kind;
    logic [RAM_AW-1:0] addr;
    logic              last;
  } req_t;

  typedef struct packed {
    logic v0;
    logic v1;
    req_t r0;
    req_t r1;
  } push_t;

  localparam logic [12:0][7:0] LET_LC = "qetuoadgjlxvn";
  localparam logic [12:0][7:0] LET_UC = "QETUOADGJLXVN";
  localparam logic [12:0][7:0] LET_LS = "wryipsfhk;cbm";
  localparam logic [12:0][7:0] LET_US = "WRYIPSFHK;CBM";
  localparam logic [7:0][7:0]  SYM_L  = ".?\\<~#&=";
  localparam logic [7:0][7:0]  SYM_U  = ",!|>`@$_";
  localparam logic [14:0][7:0] COMMON = "()' 0123456789.";

  function automatic logic [7:0] char_rom(input logic [RAM_AW-1:0] addr);
    logic [1:0] row;
    logic [5:0] key;
    logic [5:0] off;
    logic [7:0] ch;
    row = addr[7:6];
    key = addr[5:0];
    off = 6'd0;
    ch  = 8'h00;
    if (key < 6'd13) begin
      off = 6'd12 - key;
      case (row)
        2'd0:    ch = LET_LC[off[3:0]];
        2'd1:    ch = LET_UC[off[3:0]];
        2'd2:    ch = LET_LS[off[3:0]];
        default: ch = LET_US[off[3:0]];
      endcase
    end else if (key < HYBRID_KEYS) begin
      off = 6'd20 - key;
      ch  = row[0] ? SYM_U[off[2:0]] : SYM_L[off[2:0]];
    end else if (key == HYBRID_KEYS) begin
      ch = row[0] ? 8'h5A : 8'h7A;
    end else if (key < 6'd37) begin
      off = 6'd36 - key;
      ch  = COMMON[off[3:0]];
    end else begin
      case (key)
        6'd37:   ch = 8'h97;
        6'd38:   ch = 8'h2B;
        6'd39:   ch = 8'h2D;
        6'd40:   ch = 8'h2A;
        6'd41:   ch = 8'h2F;
        6'd42:   ch = 8'h25;
        6'd43:   ch = 8'h2F;
        6'd44:   ch = 8'h5E;
        6'd45:   ch = 8'hA9;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

// ===== sv/mtk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mtk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mtk_core.sv =====
// Multi-tap entry state: pending key, toggle, shift latch, timeout window, lookup requests.
module mtk_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               fire_i,
  input  mtk_pkg::in_t       in_i,
  output mtk_pkg::push_t     push_o
);

  logic        pv_q, pv_d;
  logic [5:0]  pk_q, pk_d;
  logic        sec_q, sec_d;
  logic        psh_q, psh_d;
  logic        sl_q, sl_d;
  logic [15:0] wc_q, wc_d;
  logic [15:0] to_q;
  logic [15:0] wload;
  logic        sl_now;
  mtk_pkg::req_t  new_req;
  mtk_pkg::push_t push;

  assign wload = (to_q == 16'd0) ? 16'd1 : to_q;

  always_comb begin
    pv_d    = pv_q;
    pk_d    = pk_q;
    sec_d   = sec_q;
    psh_d   = psh_q;
    sl_d    = sl_q;
    wc_d    = wc_q;
    sl_now  = sl_q;
    new_req = '0;
    push    = '0;
    if (fire_i) begin
      unique case (mtk_pkg::op_e'(in_i.operation))
        mtk_pkg::OP_KEY: begin
          if (pv_q && in_i.key == pk_q) begin
            sec_d        = ~sec_q;
            push.v0      = 1'b1;
            push.r0.kind = mtk_pkg::KIND_SWITCH;
            push.r0.addr = {~sec_q, psh_q, pk_q};
            wc_d         = wload;
          end else begin
            if (pv_q) begin
              push.v0      = 1'b1;
              push.r0.kind = mtk_pkg::KIND_DETERMINED;
              push.r0.addr = {sec_q, psh_q, pk_q};
              sl_now       = 1'b0;
              sl_d         = 1'b0;
              pv_d         = 1'b0;
              wc_d         = 16'd0;
            end
            if ({1'b0, in_i.key} < mtk_pkg::TABLE_KEYS) begin
              if (in_i.key >= mtk_pkg::HYBRID_KEYS) begin
                new_req.kind = mtk_pkg::KIND_NONHYBRID;
              end else begin
                new_req.kind = mtk_pkg::KIND_PENDING;
                pv_d         = 1'b1;
                pk_d         = in_i.key;
                sec_d        = 1'b0;
                psh_d        = sl_now;
                wc_d         = wload;
              end
              new_req.addr = {1'b0, sl_now, in_i.key};
              if (push.v0) begin
                push.v1 = 1'b1;
                push.r1 = new_req;
              end else begin
                push.v0 = 1'b1;
                push.r0 = new_req;
              end
            end
          end
        end
        mtk_pkg::OP_TICK: begin
          if (pv_q) begin
            if (wc_q > 16'd1) begin
              wc_d = wc_q - 16'd1;
            end else begin
              push.v0      = 1'b1;
              push.r0.kind = mtk_pkg::KIND_DETERMINED;
              push.r0.addr = {sec_q, psh_q, pk_q};
              sl_d         = 1'b0;
              pv_d         = 1'b0;
              wc_d         = 16'd0;
            end
          end
        end
        mtk_pkg::OP_SHIFT: begin
          sl_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
    push.r0.last = ~push.v1;
    push.r1.last = 1'b1;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      pk_q  <= 6'd0;
      sec_q <= 1'b0;
      psh_q <= 1'b0;
      sl_q  <= 1'b0;
      wc_q  <= 16'd0;
      to_q  <= mtk_pkg::TIMEOUT_RST;
    end else begin
      pv_q  <= pv_d;
      pk_q  <= pk_d;
      sec_q <= sec_d;
      psh_q <= psh_d;
      sl_q  <= sl_d;
      wc_q  <= wc_d;
      if (cfg_we_i) begin
        to_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== sv/multi_tap_key_input.sv =====
// Top level: character RAM load, lookup request queue, RAM read and output queue.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o  | in_data_i  (operation, key)
//  out     | output    | out_valid_o / out_stall_i| out_data_o (kind, character, last)
//  cfg     | input     | cfg_we_i                 | cfg_data_i (timeout_ticks)
//
// One item per cycle when it gives at most one beat and out_stall_i is low; a key press that
// gives a determined and a new beat queues two reads on the single RAM read port and can stall.
// After reset the character RAM is loaded from the ROM, all 256 addresses, with
// in_stall_o high; cfg writes are taken during the load.
// Output beats pass through the request queue, the registered RAM read and the output queue;
// out_stall_i backs up into the queues and then raises in_stall_o.
module multi_tap_key_input (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mtk_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mtk_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned FILL_W = mtk_pkg::RAM_AW + 1;

  logic [FILL_W-1:0] fill_q;
  logic              fill_busy;
  logic              fire;
  mtk_pkg::push_t    push;
  logic              p0, p1;

  mtk_pkg::req_t              req_q [mtk_pkg::REQ_DEPTH];
  logic [mtk_pkg::REQ_AW-1:0] req_wr_q, req_rd_q;
  logic [mtk_pkg::REQ_CW-1:0] req_cnt_q;
  mtk_pkg::req_t              head;
  logic                       issue;

  logic                       rd_v_q;
  mtk_pkg::kind_e             rd_kind_q;
  logic                       rd_last_q;
  logic [mtk_pkg::CHAR_W-1:0] rdata;

  mtk_pkg::out_t out_q [2];
  logic          out_wr_q, out_rd_q;
  logic [1:0]    out_cnt_q;
  logic          pop;
  logic [2:0]    occ;

  assign fill_busy  = ~fill_q[FILL_W-1];
  assign in_stall_o = fill_busy ||
                      (req_cnt_q > mtk_pkg::REQ_CW'(mtk_pkg::REQ_DEPTH - 2));
  assign fire       = in_valid_i && !in_stall_o;

  mtk_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .in_i       (in_data_i),
    .push_o     (push)
  );

  assign p0 = push.v0;
  assign p1 = push.v1;

  mtk_ram #(
    .WIDTH (mtk_pkg::CHAR_W),
    .DEPTH (mtk_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (fill_busy),
    .waddr_i (fill_q[mtk_pkg::RAM_AW-1:0]),
    .wdata_i (mtk_pkg::char_rom(fill_q[mtk_pkg::RAM_AW-1:0])),
    .raddr_i (head.addr),
    .rdata_o (rdata)
  );

  assign head  = req_q[req_rd_q];
  assign pop   = out_valid_o && !out_stall_i;
  // slots in the output queue after this edge, counting the read in flight
  assign occ   = {1'b0, out_cnt_q} + 3'(rd_v_q) - 3'(pop);
  assign issue = (req_cnt_q != '0) && (occ < 3'd2);

  always_ff @(posedge clk_i) begin
    if (p0) begin
      req_q[req_wr_q] <= push.r0;
    end
    if (p1) begin
      req_q[req_wr_q + mtk_pkg::REQ_AW'(1)] <= push.r1;
    end
    rd_kind_q <= head.kind;
    rd_last_q <= head.last;
    if (rd_v_q) begin
      out_q[out_wr_q] <= '{kind: rd_kind_q, character: rdata, last: rd_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      req_wr_q  <= '0;
      req_rd_q  <= '0;
      req_cnt_q <= '0;
      rd_v_q    <= 1'b0;
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (fill_busy) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      req_wr_q  <= req_wr_q + mtk_pkg::REQ_AW'(p0) + mtk_pkg::REQ_AW'(p1);
      req_rd_q  <= req_rd_q + mtk_pkg::REQ_AW'(issue);
      req_cnt_q <= req_cnt_q + mtk_pkg::REQ_CW'(p0) + mtk_pkg::REQ_CW'(p1)
                   - mtk_pkg::REQ_CW'(issue);
      rd_v_q    <= issue;
      out_wr_q  <= out_wr_q ^ rd_v_q;
      out_rd_q  <= out_rd_q ^ pop;
      out_cnt_q <= out_cnt_q + 2'(rd_v_q) - 2'(pop);
    end
  end

  assign out_valid_o = (out_cnt_q != 2'd0);
  assign out_data_o  = out_q[out_rd_q];

  // read data must always find a free output slot
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (out_cnt_q < 2'd2) || pop)
    else $error("output queue overrun");

  a_no_fire_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_busy |-> !fire)
    else $error("item taken during RAM load");

  a_req_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_cnt_q <= mtk_pkg::REQ_CW'(mtk_pkg::REQ_DEPTH))
    else $error("request queue overflow");

  a_out_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= 2'd2)
    else $error("output count out of range");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multi_tap_key_input: directed key table, then random phases.
module testbench;
  import mtk_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS = 155;
  localparam out_t NO_BEAT = '0;

  typedef struct packed {
    logic       typed;
    logic [1:0] cnt;
    in_t        item;
    out_t       e0;
    out_t       e1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  // predictor state
  logic [7:0]  key_chars [256];
  logic [15:0] timeout_reg;
  logic        pend_valid;
  logic [5:0]  pend_key;
  logic        sec_sel;
  logic        pend_shift;
  logic        shift_latch;
  logic [15:0] window_cnt;
  out_t        step_out [2];
  int          step_n;

  out_t        expected_chars [$];
  dir_row_t    directed_rows [$];
  out_t        want_beat;
  int          errors = 0;
  int          snd_pct = 0;
  int          rcv_pct = 0;
  int          cycle_cnt = 0;

  always #2 clk = ~clk;

  multi_tap_key_input dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  function automatic out_t char_beat(logic [1:0] kind, logic [7:0] ch, logic last);
    return {kind, ch, last};
  endfunction

  function void add_beat(kind_e kind, logic [7:0] ch);
    step_out[step_n] = char_beat(kind, ch, 1'b0);
    step_n++;
  endfunction

  function void settle_pending();
    add_beat(KIND_DETERMINED, key_chars[{sec_sel, pend_shift, pend_key}]);
    shift_latch = 1'b0;
    pend_valid  = 1'b0;
    window_cnt  = '0;
  endfunction

  function void compute_chars(in_t it);
    logic [15:0] reload;
    reload = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    step_n = 0;
    case (it.operation)
      OP_TICK: begin
        if (pend_valid) begin
          if (window_cnt > 16'd1) window_cnt--;
          else settle_pending();
        end
      end
      OP_SHIFT: shift_latch = 1'b1;
      OP_KEY: begin
        if (pend_valid && it.key == pend_key) begin
          sec_sel = ~sec_sel;
          add_beat(KIND_SWITCH, key_chars[{sec_sel, pend_shift, pend_key}]);
          window_cnt = reload;
        end else begin
          if (pend_valid) settle_pending();
          if (it.key < TABLE_KEYS) begin
            if (it.key >= HYBRID_KEYS) begin
              add_beat(KIND_NONHYBRID, key_chars[{1'b0, shift_latch, it.key}]);
            end else begin
              pend_valid = 1'b1;
              pend_key   = it.key;
              sec_sel    = 1'b0;
              pend_shift = shift_latch;
              window_cnt = reload;
              add_beat(KIND_PENDING, key_chars[{1'b0, shift_latch, it.key}]);
            end
          end
        end
      end
      default: ;
    endcase
    if (step_n > 0) step_out[step_n-1].last = 1'b1;
  endfunction

  function void add_row(logic [1:0] op, logic [5:0] key, logic typed, logic [1:0] cnt,
                        out_t e0, out_t e1);
    directed_rows.push_back({typed, cnt, op, key, e0, e1});
  endfunction

  // mostly well-formed entry: repeats of the pending key, fresh keys, ticks, shifts
  function in_t random_item();
    logic [1:0] op;
    logic [5:0] key;
    int r;
    r   = $urandom_range(99);
    key = 6'($urandom_range(63));
    op  = OP_KEY;
    if (r < 30) key = pend_valid ? pend_key : 6'($urandom_range(20));
    else if (r < 50) key = 6'($urandom_range(20));
    else if (r < 58) key = 6'($urandom_range(45, 21));
    else if (r < 63) key = 6'($urandom_range(63, 46));
    else if (r < 85) op = OP_TICK;
    else if (r < 95) op = OP_SHIFT;
    else op = OP_UNUSED;
    return {op, key};
  endfunction

  // entered and left just after a falling edge
  task automatic send_item(in_t it, logic typed, logic [1:0] cnt, out_t e0, out_t e1);
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_chars(it);
    if (typed) begin
      if (cnt > 0) expected_chars.push_back(e0);
      if (cnt > 1) expected_chars.push_back(e1);
    end else begin
      for (int i = 0; i < step_n; i++) expected_chars.push_back(step_out[i]);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    timeout_reg = v;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: kind %0d char %h last %0d",
                   out_data.kind, out_data.character, out_data.last);
      end else begin
        want_beat = expected_chars.pop_front();
        if (out_data.kind !== want_beat.kind || out_data.character !== want_beat.character ||
            out_data.last !== want_beat.last) begin
          errors++;
          if (errors <= 10)
            $display("beat mismatch: kind %0d/%0d char %h/%h last %0d/%0d (exp/got)",
                     want_beat.kind, out_data.kind, want_beat.character,
                     out_data.character, want_beat.last, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    string row_s;
    string ops_s;
    logic [15:0] phase_cfg;

    ops_s = "+-*/%/^";
    for (int r = 0; r < 4; r++) begin
      case (r)
        0:       row_s = "qetuoadgjlxvn.?\\<~#&=z()' 0123456789.";
        1:       row_s = "QETUOADGJLXVN,!|>`@$_Z()' 0123456789.";
        2:       row_s = "wryipsfhk;cbm.?\\<~#&=z()' 0123456789.";
        default: row_s = "WRYIPSFHK;CBM,!|>`@$_Z()' 0123456789.";
      endcase
      for (int k = 0; k < 64; k++)
        key_chars[r*64+k] = (k < 37) ? row_s[k] : (k == 37) ? 8'h97 :
                            (k < 45) ? ops_s[k-38] : (k == 45) ? 8'hA9 : 8'h00;
    end
    timeout_reg = TIMEOUT_RST;
    pend_valid  = 1'b0;
    pend_key    = '0;
    sec_sel     = 1'b0;
    pend_shift  = 1'b0;
    shift_latch = 1'b0;
    window_cnt  = '0;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // short window so the timeout is reached with two ticks
    write_timeout(16'd2);
    add_row(OP_TICK,   6'd0,  1'b1, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_KEY,    6'd0,  1'b1, 2'd1, char_beat(KIND_PENDING, "q", 1'b1), NO_BEAT);
    add_row(OP_KEY,    6'd0,  1'b1, 2'd1, char_beat(KIND_SWITCH, "w", 1'b1), NO_BEAT);
    add_row(OP_KEY,    6'd0,  1'b1, 2'd1, char_beat(KIND_SWITCH, "q", 1'b1), NO_BEAT);
    add_row(OP_TICK,   6'd0,  1'b1, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_TICK,   6'd0,  1'b1, 2'd1, char_beat(KIND_DETERMINED, "q", 1'b1), NO_BEAT);
    add_row(OP_SHIFT,  6'd0,  1'b1, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_KEY,    6'd20, 1'b1, 2'd1, char_beat(KIND_PENDING, "_", 1'b1), NO_BEAT);
    // shift while pending: pending char keeps its captured shift
    add_row(OP_SHIFT,  6'd63, 1'b1, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_KEY,    6'd20, 1'b1, 2'd1, char_beat(KIND_SWITCH, "_", 1'b1), NO_BEAT);
    add_row(OP_KEY,    6'd45, 1'b1, 2'd2, char_beat(KIND_DETERMINED, "_", 1'b0),
            char_beat(KIND_NONHYBRID, 8'hA9, 1'b1));
    add_row(OP_SHIFT,  6'd0,  1'b1, 2'd0, NO_BEAT, NO_BEAT);
    // non-hybrid keys keep the shift latch
    add_row(OP_KEY,    6'd37, 1'b1, 2'd1, char_beat(KIND_NONHYBRID, 8'h97, 1'b1), NO_BEAT);
    add_row(OP_KEY,    6'd21, 1'b1, 2'd1, char_beat(KIND_NONHYBRID, "Z", 1'b1), NO_BEAT);
    add_row(OP_KEY,    6'd63, 1'b1, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_KEY,    6'd5,  1'b1, 2'd1, char_beat(KIND_PENDING, "A", 1'b1), NO_BEAT);
    add_row(OP_KEY,    6'd63, 1'b1, 2'd1, char_beat(KIND_DETERMINED, "A", 1'b1), NO_BEAT);
    add_row(OP_UNUSED, 6'd63, 1'b1, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_KEY,    6'd0,  1'b1, 2'd1, char_beat(KIND_PENDING, "q", 1'b1), NO_BEAT);
    add_row(OP_KEY,    6'd12, 1'b0, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_KEY,    6'd46, 1'b0, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_KEY,    6'd36, 1'b0, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_KEY,    6'd13, 1'b0, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_TICK,   6'd42, 1'b0, 2'd0, NO_BEAT, NO_BEAT);
    add_row(OP_TICK,   6'd21, 1'b0, 2'd0, NO_BEAT, NO_BEAT);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].cnt,
                directed_rows[i].e0, directed_rows[i].e1);
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin phase_cfg = 16'd1;     snd_pct = 0;  rcv_pct = 0;  end
        1: begin phase_cfg = 16'd0;     snd_pct = 61; rcv_pct = 0;  end
        2: begin phase_cfg = 16'hFFFF;  snd_pct = 0;  rcv_pct = 61; end
        3: begin phase_cfg = 16'd3;     snd_pct = 26; rcv_pct = 26; end
        4: begin phase_cfg = 16'($urandom_range(8, 1)); snd_pct = 0; rcv_pct = 0; end
        default: begin phase_cfg = 16'd2; snd_pct = 61; rcv_pct = 61; end
      endcase
      write_timeout(phase_cfg);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_item(random_item(), 1'b0, 2'd0, NO_BEAT, NO_BEAT);
      in_valid <= 1'b0;
      drain();
    end

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
